// ===== design/cfla_pkg.sv =====
// Package with the shared types, constants and helper functions of the slot allocator.
package cfla_pkg;

  // Pool size and derived widths.
  localparam int SLOTS   = 32;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int TOTAL_W = $clog2(SLOTS + 1);

  // Fixed widths of the request and result fields.
  localparam int IDX_W  = 5;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 6;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [TOTAL_W-1:0] total_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_REJECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LINK2
  } state_t;

  // One write port on each link memory.
  typedef struct packed {
    logic  right_we;
    slot_t right_addr;
    slot_t right_data;
    logic  left_we;
    slot_t left_addr;
    slot_t left_data;
  } cfla_link_wr_t;

  // Finished result handed from the controller to the output register.
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] granted;
    status_t          status;
    logic [CNT_W-1:0] count;
  } cfla_res_t;

  // Controller status seen by the top level.
  typedef struct packed {
    logic             idle;
    total_t           free_total;
    logic [SLOTS-1:0] in_use;
  } cfla_stat_t;

  // Reset value of the right link of a slot.
  function automatic slot_t next_slot(input slot_t i);
    slot_t res;
    if (32'(i) == SLOTS - 1) begin
      res = '0;
    end else begin
      res = i + slot_t'(1);
    end
    return res;
  endfunction

  // Reset value of the left link of a slot.
  function automatic slot_t prev_slot(input slot_t i);
    slot_t res;
    if (i == '0) begin
      res = slot_t'(SLOTS - 1);
    end else begin
      res = i - slot_t'(1);
    end
    return res;
  endfunction

endpackage

// ===== design/circular_free_list_allocator_unit.sv =====
// Top level of the circular free-list slot allocator.
//
// Requests arrive on in_valid/in_ready: in_action 0 allocates a slot, 1 returns
// in_slot_index to the pool. Every request gives exactly one result on
// out_valid/out_ready: the granted slot (0 unless an allocate succeeded), a
// status (done, pool empty, free rejected) and the free count after the request.
// Free slots sit in a circular doubly linked list kept in two link RAMs with a
// registered read; the head's links are read while the block waits.
// For an allocate, a rejected request or a free into an empty pool, the result
// is made in ST_EXEC and then registered; a free into a non-empty pool also passes
// ST_LINK2, because it rewrites two entries of each link RAM, one per cycle.
// One request is in flight at a time; the next is taken as the result leaves.
// After reset all slots are free, the ring runs 0,1,...,SLOTS-1 and the head is
// slot 0; untouched link entries read as that ring, so no clearing pass is run.
// If out_ready stays low, the result waits in the output register and no new
// request is accepted until it is taken.
module circular_free_list_allocator_unit import cfla_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [IDX_W-1:0] in_slot_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_granted_slot,
  output logic [STAT_W-1:0] out_status,
  output logic [CNT_W-1:0] out_free_count
);

  slot_t         rd_addr;
  slot_t         rd_right;
  slot_t         rd_left;
  cfla_link_wr_t link_wr;
  cfla_res_t     res;
  cfla_stat_t    stat;
  logic          start;
  logic          out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] granted_r;
  status_t       status_r;
  logic [CNT_W-1:0] count_r;

  // Take a request only when idle and the output register is free or draining.
  assign in_ready = stat.idle && (!out_valid_r || out_ready);
  assign start    = in_valid && in_ready;

  cfla_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_action     (in_action),
    .in_slot_index (in_slot_index),
    .rd_right      (rd_right),
    .rd_left       (rd_left),
    .rd_addr       (rd_addr),
    .link_wr       (link_wr),
    .res           (res),
    .stat          (stat)
  );

  cfla_link_store u_links (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .link_wr  (link_wr),
    .rd_right (rd_right),
    .rd_left  (rd_left)
  );

  // Output register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (res.done) begin
      granted_r <= res.granted;
      status_r  <= res.status;
      count_r   <= res.count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = granted_r;
  assign out_status       = status_r;
  assign out_free_count   = count_r;

  // Every slot is either free or in use.
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(stat.in_use) + 32'(stat.free_total)) == SLOTS)
    else $error("free count and in-use bits disagree");

  // A result is never produced while the previous one still waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> (!out_valid_r || out_ready || $past(out_ready)))
    else $error("result produced over a pending result");

  // The block is busy in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("request accepted while a request is in flight");

  // Failed requests grant nothing, and an empty pool reports a zero count.
  a_fail_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_DONE) |-> (out_granted_slot == '0))
    else $error("slot granted on a failed request");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_EMPTY) |-> (out_free_count == '0))
    else $error("pool empty reported with free slots");

endmodule

// ===== design/cfla_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module cfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/cfla_link_store.sv =====
// Right and left link memories, with written flags that stand in for the reset ring.
module cfla_link_store import cfla_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  slot_t         rd_addr,
  input  cfla_link_wr_t link_wr,
  output slot_t         rd_right,
  output slot_t         rd_left
);

  logic [SLOTS-1:0] right_vld_r, right_vld_nxt;
  logic [SLOTS-1:0] left_vld_r, left_vld_nxt;
  slot_t            rd_addr_r;
  slot_t            right_q;
  slot_t            left_q;

  cfla_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_right_ram (
    .clk   (clk),
    .we    (link_wr.right_we),
    .waddr (link_wr.right_addr),
    .wdata (link_wr.right_data),
    .raddr (rd_addr),
    .rdata (right_q)
  );

  cfla_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_left_ram (
    .clk   (clk),
    .we    (link_wr.left_we),
    .waddr (link_wr.left_addr),
    .wdata (link_wr.left_data),
    .raddr (rd_addr),
    .rdata (left_q)
  );

  // An entry counts as written from its first write on.
  always_comb begin
    right_vld_nxt = right_vld_r;
    left_vld_nxt  = left_vld_r;
    if (link_wr.right_we) begin
      right_vld_nxt[link_wr.right_addr] = 1'b1;
    end
    if (link_wr.left_we) begin
      left_vld_nxt[link_wr.left_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_vld_r <= '0;
      left_vld_r  <= '0;
    end else begin
      right_vld_r <= right_vld_nxt;
      left_vld_r  <= left_vld_nxt;
    end
  end

  // Read address follows the RAM's read register.
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr;
  end

  // Unwritten entries read as the initial ring.
  assign rd_right = right_vld_r[rd_addr_r] ? right_q : next_slot(rd_addr_r);
  assign rd_left  = left_vld_r[rd_addr_r]  ? left_q  : prev_slot(rd_addr_r);

endmodule

// ===== design/cfla_ctrl.sv =====
// Sequencer that reads the head's links, rewrites the ring and keeps head, count and in-use bits.
module cfla_ctrl import cfla_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_action,
  input  logic [IDX_W-1:0] in_slot_index,
  input  slot_t            rd_right,
  input  slot_t            rd_left,
  output slot_t            rd_addr,
  output cfla_link_wr_t    link_wr,
  output cfla_res_t        res,
  output cfla_stat_t       stat
);

  state_t           state_r, state_nxt;
  act_t             act_r;
  slot_t            idx_r;
  logic             oob_r;
  slot_t            head_r, head_nxt;
  total_t           total_r, total_nxt;
  logic [SLOTS-1:0] in_use_r, in_use_nxt;
  logic             reject;
  logic             pool_empty;

  assign pool_empty = (total_r == '0);
  assign reject     = oob_r || !in_use_r[idx_r];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (act_r == ACT_FREE && !reject && !pool_empty) begin
          state_nxt = ST_LINK2;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LINK2: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory writes, result and bookkeeping updates.
  always_comb begin
    link_wr     = '0;
    res         = '0;
    res.status  = STAT_DONE;
    head_nxt    = head_r;
    total_nxt   = total_r;
    in_use_nxt  = in_use_r;
    case (state_r)
      ST_EXEC: begin
        if (act_r == ACT_ALLOC) begin
          if (pool_empty) begin
            res.done   = 1'b1;
            res.status = STAT_EMPTY;
          end else begin
            // Unlink the head: left[r] = l, right[l] = r.
            link_wr.left_we    = 1'b1;
            link_wr.left_addr  = rd_right;
            link_wr.left_data  = rd_left;
            link_wr.right_we   = 1'b1;
            link_wr.right_addr = rd_left;
            link_wr.right_data = rd_right;
            head_nxt           = rd_right;
            total_nxt          = total_r - total_t'(1);
            in_use_nxt[head_r] = 1'b1;
            res.done           = 1'b1;
            res.granted        = IDX_W'(head_r);
          end
        end else if (reject) begin
          res.done   = 1'b1;
          res.status = STAT_REJECT;
        end else if (pool_empty) begin
          // Rebuild a one-element ring.
          link_wr.right_we   = 1'b1;
          link_wr.right_addr = idx_r;
          link_wr.right_data = idx_r;
          link_wr.left_we    = 1'b1;
          link_wr.left_addr  = idx_r;
          link_wr.left_data  = idx_r;
          head_nxt           = idx_r;
          total_nxt          = total_r + total_t'(1);
          in_use_nxt[idx_r]  = 1'b0;
          res.done           = 1'b1;
        end else begin
          // First half of the insert: right[idx] = r, left[r] = idx.
          link_wr.right_we   = 1'b1;
          link_wr.right_addr = idx_r;
          link_wr.right_data = rd_right;
          link_wr.left_we    = 1'b1;
          link_wr.left_addr  = rd_right;
          link_wr.left_data  = idx_r;
        end
      end
      ST_LINK2: begin
        // Second half of the insert: right[h] = idx, left[idx] = h.
        link_wr.right_we   = 1'b1;
        link_wr.right_addr = head_r;
        link_wr.right_data = idx_r;
        link_wr.left_we    = 1'b1;
        link_wr.left_addr  = idx_r;
        link_wr.left_data  = head_r;
        head_nxt           = idx_r;
        total_nxt          = total_r + total_t'(1);
        in_use_nxt[idx_r]  = 1'b0;
        res.done           = 1'b1;
      end
      default: begin
      end
    endcase
    res.count = CNT_W'(total_nxt);
  end

  // The head's links are read while waiting, so they are ready on the first work cycle.
  assign rd_addr = head_r;

  assign stat.idle       = (state_r == ST_IDLE);
  assign stat.free_total = total_r;
  assign stat.in_use     = in_use_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= '0;
      total_r  <= total_t'(SLOTS);
      in_use_r <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      total_r  <= total_nxt;
      in_use_r <= in_use_nxt;
    end
  end

  // Captured request.
  always_ff @(posedge clk) begin
    if (start) begin
      act_r <= act_t'(in_action);
      idx_r <= slot_t'(in_slot_index);
      oob_r <= (32'(in_slot_index) >= SLOTS);
    end
  end

endmodule

// ===== tb/tb_circular_free_list_allocator_unit.sv =====
// Self-checking testbench for the circular free-list slot allocator.
`timescale 1ns / 100ps

module tb_circular_free_list_allocator_unit import cfla_pkg::*;;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  // One expected result of the allocator.
  typedef struct {
    logic [IDX_W-1:0]  granted;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } pool_result_t;

  // Mirror of the free ring plus the queue of results still owed by the block.
  class slot_pool_scoreboard;
    slot_t        right_link[SLOTS];
    slot_t        left_link[SLOTS];
    slot_t        head;
    int unsigned  free_total;
    bit           in_use[SLOTS];
    pool_result_t pending_results[$];
    int           errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        right_link[i] = slot_t'((i + 1) % SLOTS);
        left_link[i]  = slot_t'((i + SLOTS - 1) % SLOTS);
        in_use[i]     = 1'b0;
      end
      head       = '0;
      free_total = SLOTS;
      errors     = 0;
    endfunction

    // Apply an accepted request to the ring and queue the result it owes.
    function void note_request(act_t act, logic [IDX_W-1:0] idx);
      pool_result_t r;
      slot_t        h;
      slot_t        rn;
      slot_t        ln;
      slot_t        s;
      r.granted = '0;
      r.status  = STAT_DONE;
      s = slot_t'(idx);
      if (act == ACT_ALLOC) begin
        if (free_total == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // Unlink the head and move it to its right neighbor.
          h  = head;
          rn = right_link[h];
          ln = left_link[h];
          left_link[rn]  = ln;
          right_link[ln] = rn;
          head           = rn;
          free_total--;
          in_use[h]      = 1'b1;
          r.granted      = IDX_W'(h);
        end
      end else if (32'(idx) >= SLOTS || !in_use[s]) begin
        r.status = STAT_REJECT;
      end else begin
        // Link the slot in after the head, or make a ring of one.
        if (free_total != 0) begin
          h  = head;
          rn = right_link[h];
          right_link[s]  = rn;
          left_link[rn]  = s;
          right_link[h]  = s;
          left_link[s]   = h;
        end else begin
          right_link[s] = s;
          left_link[s]  = s;
        end
        head = s;
        free_total++;
        in_use[s] = 1'b0;
      end
      r.count = CNT_W'(free_total);
      pending_results.push_back(r);
    endfunction

    // Compare one result from the block with the oldest expectation.
    function void check_result(logic [IDX_W-1:0] granted, logic [STAT_W-1:0] status,
                               logic [CNT_W-1:0] count);
      pool_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result: granted_slot %0d status %0d free_count %0d",
               granted, status, count);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (granted !== e.granted) begin
        $error("granted_slot: expected %0d, got %0d", e.granted, granted);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (count !== e.count) begin
        $error("free_count: expected %0d, got %0d", e.count, count);
        errors++;
      end
    endfunction

    // Pick a slot that is currently handed out, or -1 if there is none.
    function int random_busy_slot();
      int busy[$];
      for (int i = 0; i < SLOTS; i++) begin
        if (in_use[i]) busy.push_back(i);
      end
      if (busy.size() == 0) return -1;
      return busy[$urandom_range(0, busy.size() - 1)];
    endfunction
  endclass

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_action = 1'b0;
  logic [IDX_W-1:0]  in_slot_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [IDX_W-1:0]  out_granted_slot;
  logic [STAT_W-1:0] out_status;
  logic [CNT_W-1:0]  out_free_count;

  int  sender_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_reqs = 0;
  int  cycle_count = 0;

  slot_pool_scoreboard pool = new();

  circular_free_list_allocator_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_slot_index    (in_slot_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status),
    .out_free_count   (out_free_count)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Result side: check each accepted result and decide the next ready.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        pool.check_result(out_granted_slot, out_status, out_free_count);
      end
      if (hold_reqs != hold_seen && hold_left == 0) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offer one request, with an optional gap first, and wait until it is taken.
  task automatic send_request(act_t act, logic [IDX_W-1:0] idx);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_slot_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pool.note_request(act, idx);
  endtask

  // Send a random free of any slot number.
  task automatic send_any_free();
    send_request(ACT_FREE, IDX_W'($urandom_range(0, SLOTS - 1)));
  endtask

  // Send a free of a slot in use, or any free if none is.
  task automatic send_busy_free();
    int b;
    b = pool.random_busy_slot();
    if (b < 0) begin
      send_any_free();
    end else begin
      send_request(ACT_FREE, IDX_W'(b));
    end
  endtask

  // Main sequence.
  initial begin
    bit filling;
    int pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: rejected frees on a full pool, double free,
    // a free of a never-granted slot, and allocates with the index ignored.
    send_request(ACT_FREE, 5'd0);
    send_request(ACT_FREE, 5'd31);
    send_request(ACT_ALLOC, 5'd31);
    send_request(ACT_ALLOC, 5'd0);
    send_request(ACT_ALLOC, 5'd21);
    send_request(ACT_FREE, 5'd1);
    send_request(ACT_FREE, 5'd1);
    send_request(ACT_FREE, 5'd30);
    send_request(ACT_ALLOC, 5'd10);
    send_request(ACT_FREE, 5'd0);
    send_request(ACT_FREE, 5'd2);
    send_request(ACT_FREE, 5'd1);
    send_request(ACT_ALLOC, 5'd0);
    send_request(ACT_ALLOC, 5'd31);
    send_request(ACT_ALLOC, 5'd15);
    send_request(ACT_FREE, 5'd2);
    send_request(ACT_FREE, 5'd31);
    send_request(ACT_ALLOC, 5'd0);

    // Random phases: the ring is driven between full and empty so that
    // empty-pool allocates, frees into an empty pool and rejects all occur.
    filling = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          sender_idle_pct = 55;
          recv_stall_pct <= 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct <= 55;
        end
        default: begin
          sender_idle_pct = 35;
          recv_stall_pct <= 35;
        end
      endcase
      for (int n = 0; n < 280; n++) begin
        if (filling && pool.free_total == 0 && $urandom_range(0, 99) < 30) filling = 1'b0;
        else if (!filling && pool.free_total == SLOTS && $urandom_range(0, 99) < 30)
          filling = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          send_any_free();
        end else if (filling == (pick < 80)) begin
          send_request(ACT_ALLOC, IDX_W'($urandom_range(0, SLOTS - 1)));
        end else begin
          send_busy_free();
        end
      end

      // Long receiver hold while requests keep coming, so the input stalls.
      if (phase == 0) begin
        hold_reqs++;
        for (int n = 0; n < 20; n++) begin
          if (n % 2 == 0) send_request(ACT_ALLOC, IDX_W'($urandom_range(0, SLOTS - 1)));
          else send_busy_free();
        end
      end
    end
    in_valid <= 1'b0;

    // Drain the outstanding results, then allow a few quiet cycles.
    while (pool.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pool.errors == 0 && pool.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
